// ----- rtl/cfar2d_pkg.sv -----
// Shared constants, codes and item types of the 2D CA-CFAR detector.
package cfar2d_pkg;

  // Geometry limits
  localparam int MAX_COLS  = 1024;
  localparam int MAX_ROWS  = 1024;
  localparam int MAX_REF   = 8;
  localparam int MAX_GUARD = 4;
  localparam int WIN_DEPTH = 2 * (MAX_REF + MAX_GUARD) + 1;

  // Field widths
  localparam int POW_W   = 24;
  localparam int POS_W   = 10;
  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int FRM_W   = 11;
  localparam int REF_W   = 4;
  localparam int GRD_W   = 3;
  localparam int WIN_W   = $clog2(MAX_REF + MAX_GUARD + 1);
  localparam int SLOT_W  = $clog2(WIN_DEPTH);
  localparam int OCS_W   = 29;
  localparam int GCS_W   = 28;
  localparam int OWS_W   = 34;
  localparam int GWS_W   = 32;
  localparam int ALPHA_W = 24;
  localparam int FRAC_W  = 16;
  localparam int THR_W   = 42;
  localparam int PROD_W  = OWS_W + ALPHA_W;

  // Column-sum delay lines in the window stage
  localparam int OLINE_D  = 2 * (MAX_REF + MAX_GUARD) + 1;
  localparam int GLINE_D  = MAX_REF + 2 * MAX_GUARD + 1;
  localparam int CLINE_D  = MAX_REF + MAX_GUARD;
  localparam int OLINE_IW = $clog2(OLINE_D);
  localparam int GLINE_IW = $clog2(GLINE_D);
  localparam int CLINE_IW = $clog2(CLINE_D);

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_REF_ROWS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_COLS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD_ROWS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD_COLS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 3'd6;

  localparam logic [REF_W-1:0]   RST_REF    = 4'd4;
  localparam logic [GRD_W-1:0]   RST_GUARD  = 3'd1;
  localparam logic [ALPHA_W-1:0] RST_ALPHA  = 24'd65536;
  localparam logic [FRM_W-1:0]   RST_FRAME  = 11'd1024;

  typedef struct packed {
    logic [POW_W-1:0] power;
    logic             frame_start;
  } in_item_t;

  typedef struct packed {
    logic             detected;
    logic [POS_W-1:0] cell_row;
    logic [POS_W-1:0] cell_col;
    logic [THR_W-1:0] noise_threshold;
  } out_item_t;

  typedef struct packed {
    logic [REF_W-1:0] rr;
    logic [REF_W-1:0] rc;
    logic [GRD_W-1:0] gr;
    logic [GRD_W-1:0] gc;
    logic [WIN_W-1:0] wr;
    logic [WIN_W-1:0] wc;
  } geom_t;

  typedef struct packed {
    logic [POW_W-1:0]  power;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [SLOT_W-1:0] slot;
    geom_t             geom;
  } a_item_t;

  typedef struct packed {
    logic [WIN_DEPTH-1:0][POW_W-1:0] smp;
    logic [OCS_W-1:0]                ocs;
    logic [GCS_W-1:0]                gcs;
  } colword_t;

  localparam int COLWORD_W = $bits(colword_t);

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [OCS_W-1:0] ocs;
    logic [GCS_W-1:0] gcs;
    logic [POW_W-1:0] cut_smp;
    geom_t            geom;
  } b_item_t;

  typedef struct packed {
    logic [POW_W-1:0] cut;
    logic [POS_W-1:0] cell_row;
    logic [POS_W-1:0] cell_col;
  } cand_t;

endpackage

// ----- rtl/cfar2d_ram.sv -----
// Simple dual-port synchronous RAM, registered read with enable.
module cfar2d_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/cfar2d_colupd.sv -----
// Column store: sample history and vertical column sums, read-modify-write.
module cfar2d_colupd (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_fire,
  input  cfar2d_pkg::a_item_t in_a,
  output logic                b_v,
  output cfar2d_pkg::b_item_t b_item
);
  import cfar2d_pkg::*;

  function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] s,
                                                  input logic [SLOT_W-1:0] k);
    logic [SLOT_W:0] t;
    t = {1'b0, s} + (SLOT_W+1)'(WIN_DEPTH) - {1'b0, k};
    if (t >= (SLOT_W+1)'(WIN_DEPTH)) t = t - (SLOT_W+1)'(WIN_DEPTH);
    return t[SLOT_W-1:0];
  endfunction

  logic                 a_v_r;
  a_item_t              a_r;
  logic                 byp_r;
  colword_t             byp_word_r;
  logic [COLWORD_W-1:0] ram_q;
  colword_t             word;
  colword_t             word_nxt;
  logic [SLOT_W-1:0]    k_o;
  logic [SLOT_W-1:0]    k_gs;
  logic [POW_W-1:0]     sub_o;
  logic [POW_W-1:0]     add_g;
  logic [POW_W-1:0]     sub_g;
  logic [POW_W-1:0]     cut_smp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      byp_r <= 1'b0;
    end else begin
      if (adv) a_v_r <= in_fire;
      // same column still being written back: take the fresh word
      if (in_fire) byp_r <= a_v_r && (a_r.col == in_a.col);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_r        <= in_a;
      byp_word_r <= word_nxt;
    end
  end

  cfar2d_ram #(
    .DEPTH(MAX_COLS),
    .WIDTH(COLWORD_W)
  ) u_ram (
    .clk  (clk),
    .we   (adv && a_v_r),
    .waddr(a_r.col),
    .wdata(word_nxt),
    .re   (in_fire),
    .raddr(in_a.col),
    .rdata(ram_q)
  );

  always_comb begin
    word  = byp_r ? byp_word_r : colword_t'(ram_q);
    k_o   = SLOT_W'({a_r.geom.wr, 1'b1});
    k_gs  = SLOT_W'(a_r.geom.rr) + SLOT_W'({a_r.geom.gr, 1'b1});

    // row leaving the outer band
    sub_o = (a_r.row >= ROW_W'(k_o)) ? word.smp[slot_back(a_r.slot, k_o)] : '0;

    // rows entering and leaving the guard band
    if (a_r.geom.rr == '0) begin
      add_g = a_r.power;
    end else if (a_r.row >= ROW_W'(a_r.geom.rr)) begin
      add_g = word.smp[slot_back(a_r.slot, SLOT_W'(a_r.geom.rr))];
    end else begin
      add_g = '0;
    end
    sub_g = (a_r.row >= ROW_W'(k_gs)) ? word.smp[slot_back(a_r.slot, k_gs)] : '0;

    cut_smp = (a_r.geom.wr == '0) ? a_r.power
                                  : word.smp[slot_back(a_r.slot, SLOT_W'(a_r.geom.wr))];

    word_nxt              = word;
    word_nxt.smp[a_r.slot] = a_r.power;
    word_nxt.ocs = ((a_r.row == '0) ? '0 : word.ocs) + OCS_W'(a_r.power) - OCS_W'(sub_o);
    word_nxt.gcs = ((a_r.row == '0) ? '0 : word.gcs) + GCS_W'(add_g) - GCS_W'(sub_g);

    b_v            = a_v_r;
    b_item.row     = a_r.row;
    b_item.col     = a_r.col;
    b_item.ocs     = word_nxt.ocs;
    b_item.gcs     = word_nxt.gcs;
    b_item.cut_smp = cut_smp;
    b_item.geom    = a_r.geom;
  end

endmodule

// ----- rtl/cfar2d_win.sv -----
// Horizontal running window sums over column sums, cell-under-test delay.
module cfar2d_win (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           b_v,
  input  cfar2d_pkg::b_item_t            b_item,
  output logic                           c_v,
  output cfar2d_pkg::cand_t              cand,
  output logic [cfar2d_pkg::OWS_W-1:0]   ows,
  output logic [cfar2d_pkg::GWS_W-1:0]   gws
);
  import cfar2d_pkg::*;

  logic              b_v_r;
  b_item_t           b_r;
  logic [OCS_W-1:0]  oline_r [OLINE_D];
  logic [GCS_W-1:0]  gline_r [GLINE_D];
  logic [POW_W-1:0]  cline_r [CLINE_D];
  logic [OWS_W-1:0]  ows_r;
  logic [GWS_W-1:0]  gws_r;
  logic [OWS_W-1:0]  ows_nxt;
  logic [GWS_W-1:0]  gws_nxt;
  logic              c_v_r;
  cand_t             cand_r;
  cand_t             cand_nxt;
  logic              dec;
  logic [OLINE_IW-1:0] o_idx;
  logic [GLINE_IW-1:0] ga_idx;
  logic [GLINE_IW-1:0] gs_idx;
  logic [OCS_W-1:0]  o_sub;
  logic [GCS_W-1:0]  g_add;
  logic [GCS_W-1:0]  g_sub;
  logic [POW_W-1:0]  cut;

  always_comb begin
    o_idx  = OLINE_IW'({b_r.geom.wc, 1'b0});
    ga_idx = GLINE_IW'(b_r.geom.rc) - GLINE_IW'(1);
    gs_idx = GLINE_IW'(b_r.geom.wc) + GLINE_IW'(b_r.geom.gc);

    o_sub = (COL_W'(b_r.col) > COL_W'(o_idx)) ? oline_r[o_idx] : '0;
    if (b_r.geom.rc == '0) begin
      g_add = b_r.gcs;
    end else if (b_r.col >= COL_W'(b_r.geom.rc)) begin
      g_add = gline_r[ga_idx];
    end else begin
      g_add = '0;
    end
    g_sub = (b_r.col > COL_W'(gs_idx)) ? gline_r[gs_idx] : '0;

    ows_nxt = ((b_r.col == '0) ? '0 : ows_r) + OWS_W'(b_r.ocs) - OWS_W'(o_sub);
    gws_nxt = ((b_r.col == '0) ? '0 : gws_r) + GWS_W'(g_add) - GWS_W'(g_sub);

    cut = (b_r.geom.wc == '0) ? b_r.cut_smp
                              : cline_r[CLINE_IW'(b_r.geom.wc) - CLINE_IW'(1)];

    dec = (b_r.row >= ROW_W'({b_r.geom.wr, 1'b0})) &&
          (b_r.col >= COL_W'({b_r.geom.wc, 1'b0}));

    cand_nxt.cut      = cut;
    cand_nxt.cell_row = POS_W'(b_r.row - ROW_W'(b_r.geom.wr));
    cand_nxt.cell_col = POS_W'(b_r.col - COL_W'(b_r.geom.wc));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      ows_r <= '0;
      gws_r <= '0;
    end else if (adv) begin
      b_v_r <= b_v;
      c_v_r <= b_v_r && dec;
      if (b_v_r) begin
        ows_r <= ows_nxt;
        gws_r <= gws_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_r    <= b_item;
      cand_r <= cand_nxt;
      if (b_v_r) begin
        oline_r[0] <= b_r.ocs;
        gline_r[0] <= b_r.gcs;
        cline_r[0] <= b_r.cut_smp;
        for (int i = 1; i < OLINE_D; i++) oline_r[i] <= oline_r[i-1];
        for (int i = 1; i < GLINE_D; i++) gline_r[i] <= gline_r[i-1];
        for (int i = 1; i < CLINE_D; i++) cline_r[i] <= cline_r[i-1];
      end
    end
  end

  assign c_v  = c_v_r;
  assign cand = cand_r;
  assign ows  = ows_r;
  assign gws  = gws_r;

endmodule

// ----- rtl/cfar2d_thr.sv -----
// Reference sum, alpha scaling and threshold compare with output register.
module cfar2d_thr (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             c_v,
  input  cfar2d_pkg::cand_t                cand,
  input  logic [cfar2d_pkg::OWS_W-1:0]     ows,
  input  logic [cfar2d_pkg::GWS_W-1:0]     gws,
  input  logic [cfar2d_pkg::ALPHA_W-1:0]   alpha,
  output logic                             out_valid,
  output cfar2d_pkg::out_item_t            out_data
);
  import cfar2d_pkg::*;

  logic              r_v_r;
  logic [OWS_W-1:0]  ref_r;
  cand_t             r_cand_r;
  logic              p_v_r;
  logic [PROD_W-1:0] prod_r;
  cand_t             p_cand_r;
  logic              out_v_r;
  out_item_t         out_r;
  logic [THR_W-1:0]  thr;

  assign thr = prod_r[PROD_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_v_r   <= 1'b0;
      p_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      r_v_r   <= c_v;
      p_v_r   <= r_v_r;
      out_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ref_r                 <= ows - OWS_W'(gws);
      r_cand_r              <= cand;
      prod_r                <= PROD_W'(ref_r) * PROD_W'(alpha);
      p_cand_r              <= r_cand_r;
      out_r.detected        <= THR_W'(p_cand_r.cut) > thr;
      out_r.cell_row        <= p_cand_r.cell_row;
      out_r.cell_col        <= p_cand_r.cell_col;
      out_r.noise_threshold <= thr;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/cfar_2d_cell_averaging_detector.sv -----
// Top level of the 2D cell-averaging CFAR detector.
// Throughput: one sample per cycle, sustained, as long as out_ready is held high.
// A decided cell's result is registered after the sample that completes its outer
// window is accepted, through column store read, window sums, reference subtract,
// alpha multiply and compare.
// Reset: synchronous, active low; clears pipeline valids, position and registers.
// The column store RAM is not cleared: row 0 of each map restarts the column sums.
module cfar_2d_cell_averaging_detector (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  cfar2d_pkg::in_item_t             in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output cfar2d_pkg::out_item_t            out_data,
  input  logic                             cfg_wr_en,
  input  logic [cfar2d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cfar2d_pkg::CFG_DW-1:0]    cfg_wdata
);
  import cfar2d_pkg::*;

  // Configuration registers (raw, saturated at frame start)
  logic [REF_W-1:0]   ref_rows_r;
  logic [REF_W-1:0]   ref_cols_r;
  logic [GRD_W-1:0]   guard_rows_r;
  logic [GRD_W-1:0]   guard_cols_r;
  logic [ALPHA_W-1:0] alpha_r;
  logic [FRM_W-1:0]   frame_rows_r;
  logic [FRM_W-1:0]   frame_cols_r;

  // Geometry latched at cell (0,0) of each map
  geom_t              lat_geom_r;
  logic [FRM_W-1:0]   lat_rows_r;
  logic [FRM_W-1:0]   lat_cols_r;

  // Raster position of the next sample; slot = row mod history depth
  logic [ROW_W-1:0]   row_pos_r;
  logic [COL_W-1:0]   col_pos_r;
  logic [SLOT_W-1:0]  slot_r;
  logic [ROW_W-1:0]   row_nxt;
  logic [COL_W-1:0]   col_nxt;
  logic [SLOT_W-1:0]  slot_nxt;

  geom_t              sat_geom;
  logic [FRM_W-1:0]   sat_rows;
  logic [FRM_W-1:0]   sat_cols;
  logic [ROW_W-1:0]   cur_row;
  logic [COL_W-1:0]   cur_col;
  logic [SLOT_W-1:0]  cur_slot;
  logic               at_origin;
  geom_t              geom_use;
  logic [FRM_W-1:0]   rows_use;
  logic [FRM_W-1:0]   cols_use;
  logic [FRM_W-1:0]   col_inc;
  logic [FRM_W-1:0]   row_inc;

  logic               adv;
  logic               in_fire;
  a_item_t            a_item;
  logic               b_v;
  b_item_t            b_item;
  logic               c_v;
  cand_t              cand;
  logic [OWS_W-1:0]   ows;
  logic [GWS_W-1:0]   gws;

  // Whole pipeline moves in lockstep; it stalls only when the output holds an
  // item that is not being taken.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign in_fire  = in_valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_rows_r   <= RST_REF;
      ref_cols_r   <= RST_REF;
      guard_rows_r <= RST_GUARD;
      guard_cols_r <= RST_GUARD;
      alpha_r      <= RST_ALPHA;
      frame_rows_r <= RST_FRAME;
      frame_cols_r <= RST_FRAME;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_REF_ROWS:   ref_rows_r   <= cfg_wdata[REF_W-1:0];
        CFG_REF_COLS:   ref_cols_r   <= cfg_wdata[REF_W-1:0];
        CFG_GUARD_ROWS: guard_rows_r <= cfg_wdata[GRD_W-1:0];
        CFG_GUARD_COLS: guard_cols_r <= cfg_wdata[GRD_W-1:0];
        CFG_ALPHA:      alpha_r      <= cfg_wdata[ALPHA_W-1:0];
        CFG_FRAME_ROWS: frame_rows_r <= cfg_wdata[FRM_W-1:0];
        CFG_FRAME_COLS: frame_cols_r <= cfg_wdata[FRM_W-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  always_comb begin
    // Saturate geometry: ref to MAX_REF, guard to MAX_GUARD, frame to [1, MAX]
    sat_geom.rr = (ref_rows_r > REF_W'(MAX_REF)) ? REF_W'(MAX_REF) : ref_rows_r;
    sat_geom.rc = (ref_cols_r > REF_W'(MAX_REF)) ? REF_W'(MAX_REF) : ref_cols_r;
    sat_geom.gr = (guard_rows_r > GRD_W'(MAX_GUARD)) ? GRD_W'(MAX_GUARD) : guard_rows_r;
    sat_geom.gc = (guard_cols_r > GRD_W'(MAX_GUARD)) ? GRD_W'(MAX_GUARD) : guard_cols_r;
    sat_geom.wr = WIN_W'(sat_geom.rr) + WIN_W'(sat_geom.gr);
    sat_geom.wc = WIN_W'(sat_geom.rc) + WIN_W'(sat_geom.gc);
    if (frame_rows_r == '0) begin
      sat_rows = FRM_W'(1);
    end else if (frame_rows_r > FRM_W'(MAX_ROWS)) begin
      sat_rows = FRM_W'(MAX_ROWS);
    end else begin
      sat_rows = frame_rows_r;
    end
    if (frame_cols_r == '0) begin
      sat_cols = FRM_W'(1);
    end else if (frame_cols_r > FRM_W'(MAX_COLS)) begin
      sat_cols = FRM_W'(MAX_COLS);
    end else begin
      sat_cols = frame_cols_r;
    end

    // frame_start forces cell (0,0); any cell (0,0) latches new geometry
    cur_row   = in_data.frame_start ? '0 : row_pos_r;
    cur_col   = in_data.frame_start ? '0 : col_pos_r;
    cur_slot  = in_data.frame_start ? '0 : slot_r;
    at_origin = (cur_row == '0) && (cur_col == '0);
    geom_use  = at_origin ? sat_geom : lat_geom_r;
    rows_use  = at_origin ? sat_rows : lat_rows_r;
    cols_use  = at_origin ? sat_cols : lat_cols_r;

    // Raster advance with implicit wrap to (0,0) after the last cell
    col_inc  = FRM_W'(cur_col) + FRM_W'(1);
    row_inc  = FRM_W'(cur_row) + FRM_W'(1);
    row_nxt  = cur_row;
    slot_nxt = cur_slot;
    if (col_inc >= cols_use) begin
      col_nxt = '0;
      if (row_inc >= rows_use) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end else begin
        row_nxt  = ROW_W'(row_inc);
        slot_nxt = (cur_slot == SLOT_W'(WIN_DEPTH - 1)) ? '0 : cur_slot + SLOT_W'(1);
      end
    end else begin
      col_nxt = COL_W'(col_inc);
    end

    a_item.power = in_data.power;
    a_item.row   = cur_row;
    a_item.col   = cur_col;
    a_item.slot  = cur_slot;
    a_item.geom  = geom_use;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r     <= '0;
      col_pos_r     <= '0;
      slot_r        <= '0;
      lat_geom_r.rr <= RST_REF;
      lat_geom_r.rc <= RST_REF;
      lat_geom_r.gr <= RST_GUARD;
      lat_geom_r.gc <= RST_GUARD;
      lat_geom_r.wr <= WIN_W'(RST_REF) + WIN_W'(RST_GUARD);
      lat_geom_r.wc <= WIN_W'(RST_REF) + WIN_W'(RST_GUARD);
      lat_rows_r    <= RST_FRAME;
      lat_cols_r    <= RST_FRAME;
    end else if (in_fire) begin
      row_pos_r  <= row_nxt;
      col_pos_r  <= col_nxt;
      slot_r     <= slot_nxt;
      lat_geom_r <= geom_use;
      lat_rows_r <= rows_use;
      lat_cols_r <= cols_use;
    end
  end

  // Column store: sample history + vertical outer/guard column sums in one RAM
  cfar2d_colupd u_colupd (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_fire(in_fire),
    .in_a   (a_item),
    .b_v    (b_v),
    .b_item (b_item)
  );

  // Running horizontal sums give the full outer and guard box sums
  cfar2d_win u_win (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .b_v   (b_v),
    .b_item(b_item),
    .c_v   (c_v),
    .cand  (cand),
    .ows   (ows),
    .gws   (gws)
  );

  // Reference sum, scale by alpha (Q8.16), strict compare
  cfar2d_thr u_thr (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .c_v      (c_v),
    .cand     (cand),
    .ows      (ows),
    .gws      (gws),
    .alpha    (alpha_r),
    .out_valid(out_valid),
    .out_data (out_data)
  );

`ifndef NO_ASSERTIONS
  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    FRM_W'(col_pos_r) < lat_cols_r)
    else $error("column position past latched frame width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    FRM_W'(row_pos_r) < lat_rows_r)
    else $error("row position past latched frame height");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r < SLOT_W'(WIN_DEPTH))
    else $error("history slot out of range");

  a_slot_row0: assert property (@(posedge clk) disable iff (!rst_n)
    (row_pos_r == '0) |-> (slot_r == '0))
    else $error("history slot not aligned with row 0");
`endif

endmodule

// ----- tb/sv/tb_cfar_2d_cell_averaging_detector.sv -----
// Self-checking testbench of the 2D cell-averaging CFAR detector.
`timescale 1ns / 100ps

module tb_cfar_2d_cell_averaging_detector;
  import cfar2d_pkg::*;

  // Predicts CFAR decisions from accepted samples and checks the results in order.
  class cfar_scoreboard;
    logic [POW_W-1:0] map_rows [WIN_DEPTH][MAX_COLS];
    int unsigned      reg_v [7];
    int unsigned      g_rr, g_rc, g_gr, g_gc, g_rows, g_cols;
    int unsigned      row_pos, col_pos;
    out_item_t        expected_q [$];
    int               errors;
    int               shown;

    function new();
      reg_v = '{4, 4, 1, 1, 65536, 1024, 1024};
      row_pos = 0;
      col_pos = 0;
      errors = 0;
      shown = 0;
      latch_geometry();
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void latch_geometry();
      g_rr   = clamp(reg_v[0], 0, MAX_REF);
      g_rc   = clamp(reg_v[1], 0, MAX_REF);
      g_gr   = clamp(reg_v[2], 0, MAX_GUARD);
      g_gc   = clamp(reg_v[3], 0, MAX_GUARD);
      g_rows = clamp(reg_v[5], 1, MAX_ROWS);
      g_cols = clamp(reg_v[6], 1, MAX_COLS);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
      case (idx)
        CFG_REF_ROWS:   reg_v[0] = v & 32'hF;
        CFG_REF_COLS:   reg_v[1] = v & 32'hF;
        CFG_GUARD_ROWS: reg_v[2] = v & 32'h7;
        CFG_GUARD_COLS: reg_v[3] = v & 32'h7;
        CFG_ALPHA:      reg_v[4] = v & 32'hFFFFFF;
        CFG_FRAME_ROWS: reg_v[5] = v & 32'h7FF;
        CFG_FRAME_COLS: reg_v[6] = v & 32'h7FF;
        default: ;
      endcase
    endfunction

    function longint unsigned box_sum(int unsigned r0, int unsigned r1,
                                      int unsigned c0, int unsigned c1);
      longint unsigned s;
      s = 0;
      for (int unsigned r = r0; r <= r1; r++)
        for (int unsigned c = c0; c <= c1; c++)
          s += map_rows[r % WIN_DEPTH][c % MAX_COLS];
      return s;
    endfunction

    function void note_sample(in_item_t it);
      int unsigned     rr, cc, wr, wc, r, c;
      longint unsigned outer, guard, thr, cut;
      out_item_t       e;
      if (it.frame_start) begin
        row_pos = 0;
        col_pos = 0;
      end
      if (row_pos == 0 && col_pos == 0) latch_geometry();
      rr = row_pos;
      cc = col_pos;
      map_rows[rr % WIN_DEPTH][cc % MAX_COLS] = it.power;
      col_pos++;
      if (col_pos >= g_cols) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= g_rows) row_pos = 0;
      end
      wr = g_rr + g_gr;
      wc = g_rc + g_gc;
      if (rr < 2 * wr || cc < 2 * wc) return;  // edge cell, no decision
      r = rr - wr;
      c = cc - wc;
      outer = box_sum(rr - 2 * wr, rr, cc - 2 * wc, cc);
      guard = box_sum(r - g_gr, r + g_gr, c - g_gc, c + g_gc);
      thr = ((outer - guard) * longint'(reg_v[4])) >> FRAC_W;
      cut = 64'(map_rows[r % WIN_DEPTH][c % MAX_COLS]);
      e.detected        = (cut > thr);
      e.cell_row        = POS_W'(r);
      e.cell_col        = POS_W'(c);
      e.noise_threshold = thr[THR_W-1:0];
      expected_q.push_back(e);
    endfunction

    function void check_decision(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result: det=%0b row=%0d col=%0d thr=%0d",
                   got.detected, got.cell_row, got.cell_col, got.noise_threshold);
        end
        return;
      end
      e = expected_q.pop_front();
      if (got.detected !== e.detected || got.cell_row !== e.cell_row ||
          got.cell_col !== e.cell_col || got.noise_threshold !== e.noise_threshold) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch: exp det=%0b row=%0d col=%0d thr=%0d",
                   e.detected, e.cell_row, e.cell_col, e.noise_threshold);
          $display("          got det=%0b row=%0d col=%0d thr=%0d",
                   got.detected, got.cell_row, got.cell_col, got.noise_threshold);
        end
      end
    endfunction
  endclass

  localparam int LIMIT = 300000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DW-1:0]    cfg_wdata = '0;

  cfar_scoreboard sb = new();
  int  cycles = 0;
  int  samples_in = 0;
  bit  dense_phase = 0;   // sender offers back to back
  bit  hold_done = 0;

  cfar_2d_cell_averaging_detector uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Monitors: predict on accepted samples, check on accepted results.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_n && in_valid && in_ready) begin
      sb.note_sample(in_data);
      samples_in <= samples_in + 1;
    end
    if (rst_n && out_valid && out_ready) sb.check_decision(out_data);
  end

  // Receiver: random back-pressure, a no-stall stretch, and one long hold-off
  // in the dense phase so the pipeline fills and stalls the input.
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (dense_phase && !hold_done && samples_in > 60) begin
      hold_cnt <= hold_cnt + 1;
      out_ready <= 1'b0;
      if (hold_cnt >= 400) hold_done <= 1'b1;
    end else if (samples_in > 400 && samples_in < 650) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 18);
    end
  end

  // Write all registers; scoreboard copy is updated alongside.
  task automatic write_regs(int unsigned rr, int unsigned rc, int unsigned gr,
                            int unsigned gc, int unsigned alpha, int unsigned rows,
                            int unsigned cols);
    logic [CFG_IDX_W-1:0] idx [7];
    int unsigned          val [7];
    idx = '{CFG_REF_ROWS, CFG_REF_COLS, CFG_GUARD_ROWS, CFG_GUARD_COLS,
            CFG_ALPHA, CFG_FRAME_ROWS, CFG_FRAME_COLS};
    val = '{rr, rc, gr, gc, alpha, rows, cols};
    for (int i = 0; i < 7; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= CFG_DW'(val[i]);
      sb.set_reg(idx[i], val[i]);
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // Offer one item and hold it until accepted; valid stays high on return.
  task automatic send_sample(logic [POW_W-1:0] pw, logic fs);
    in_valid <= 1'b1;
    in_data  <= '{power: pw, frame_start: fs};
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic maybe_idle();
    if (!dense_phase && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);  // let edge-cell samples leave the pipeline
  endtask

  function automatic logic [POW_W-1:0] rand_power();
    case ($urandom_range(3))
      0: return POW_W'($urandom());
      1: return $urandom_range(1) ? '1 : '0;
      default: return POW_W'($urandom_range(255));
    endcase
  endfunction

  task automatic run_samples(int n, bit restart);
    for (int i = 0; i < n; i++) begin
      send_sample(rand_power(), (i == 0 && restart) || ($urandom_range(199) == 0));
      maybe_idle();
    end
    drain();
  endtask

  initial begin
    int unsigned rr, rc, gr, gc, alpha, rows, cols;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 3x3 maps, one-cell reference ring, threshold equals ring sum.
    write_regs(1, 1, 0, 0, 65536, 3, 3);
    // lone hot cell over a zero ring: detected at threshold 0
    for (int i = 0; i < 9; i++) send_sample((i == 4) ? '1 : '0, i == 0);
    // flat maximum map: not detected, threshold at eight times the maximum
    for (int i = 0; i < 9; i++) send_sample('1, 1'b0);
    // a map that wraps in implicitly, then a frame restart in mid-map
    for (int i = 0; i < 4; i++) send_sample(24'h5A5A5A, 1'b0);
    for (int i = 0; i < 9; i++) send_sample(POW_W'(i + 1), i == 0);
    drain();
    // unknown index is ignored
    cfg_wr_en <= 1'b1;
    cfg_index <= 3'd7;
    cfg_wdata <= '1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;

    // Frame rows saturate to the maximum, zero columns count as one.
    write_regs(1, 0, 0, 0, 32768, 2047, 0);
    run_samples(20, 1);
    // One row of saturated width, zero reference rows.
    write_regs(0, 1, 0, 0, 24'hFFFFFF, 1, 2047);
    run_samples(30, 1);

    // Dense phase with receiver hold-off.
    dense_phase = 1;
    write_regs(1, 1, 0, 1, 8192, 12, 12);
    run_samples(120, 1);
    dense_phase = 0;

    // Random geometries, mostly small windows.
    for (int p = 0; p < 3; p++) begin
      rr = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(2);
      rc = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(2);
      gr = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(1);
      gc = ($urandom_range(3) == 0) ? $urandom_range(7) : $urandom_range(1);
      case ($urandom_range(3))
        0: alpha = $urandom_range(24'hFFFFFF);
        1: alpha = $urandom_range(1) ? 0 : 24'hFFFFFF;
        default: alpha = $urandom_range(16384);
      endcase
      rows = $urandom_range(1, 14);
      cols = ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 16);
      write_regs(rr, rc, gr, gc, alpha, rows, cols);
      run_samples(45, $urandom_range(1) != 0);
    end

    // Largest window, saturated register values, maximum alpha.
    write_regs(15, 8, 7, 4, 24'hFFFFFF, 25, 25);
    run_samples(625, 1);

    if (sb.expected_q.size() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cfar2d_pkg.sv
rtl/cfar2d_ram.sv
rtl/cfar2d_colupd.sv
rtl/cfar2d_win.sv
rtl/cfar2d_thr.sv
rtl/cfar_2d_cell_averaging_detector.sv
tb/sv/tb_cfar_2d_cell_averaging_detector.sv
